/* src/fhls_pkg.sv */
// shared types and constants for the frame header, length and sum checker
`default_nettype none
package fhls_pkg;

   localparam int BYTE_WIDTH = 8;
   localparam int POS_WIDTH = 9;
   localparam int VERDICT_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;

   localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

   // register index taken from the word address
   localparam logic CSR_IDX_HEADER = 1'b0;

   typedef enum logic [VERDICT_WIDTH-1:0] {
      VERDICT_OK        = 3'd0,
      VERDICT_HEADER    = 3'd1,
      VERDICT_SHORT     = 3'd2,
      VERDICT_LONG      = 3'd3,
      VERDICT_SUM       = 3'd4
   } verdict_type;

   typedef struct packed {
      logic        valid;
      verdict_type verdict;
   } check_result_type;

endpackage
`default_nettype wire

/* src/fhls_csr.sv */
// configuration register file: header byte
`default_nettype none
module fhls_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [fhls_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  wire logic [fhls_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic      [fhls_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                      pready,
   output logic      [fhls_pkg::BYTE_WIDTH-1:0]      header_byte
);

   logic [fhls_pkg::BYTE_WIDTH-1:0] header_ff;
   logic [fhls_pkg::BYTE_WIDTH-1:0] header_in;
   logic                            reg_idx;
   logic                            wr_en;

   assign reg_idx = paddr[fhls_pkg::CSR_ADDR_WIDTH-1];
   assign wr_en   = psel && penable && pwrite && (reg_idx == fhls_pkg::CSR_IDX_HEADER);

   always_comb begin
      header_in = header_ff;
      if (wr_en) begin
         header_in = pwdata[fhls_pkg::BYTE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= '0;
      end else begin
         header_ff <= header_in;
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         fhls_pkg::CSR_IDX_HEADER: prdata[fhls_pkg::BYTE_WIDTH-1:0] = header_ff;
         default:                  prdata = '0;
      endcase
   end

   assign pready      = 1'b1;
   assign header_byte = header_ff;

endmodule
`default_nettype wire

/* src/fhls_check.sv */
// per-frame state and verdict logic, one word per cycle while go is high
`default_nettype none
module fhls_check (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             go,
   input  wire logic [fhls_pkg::BYTE_WIDTH-1:0]  data_byte,
   input  wire logic                             frame_end,
   input  wire logic [fhls_pkg::BYTE_WIDTH-1:0]  header_byte,
   output fhls_pkg::check_result_type            result
);

   logic [fhls_pkg::POS_WIDTH-1:0]  pos_ff, pos_in;
   logic [fhls_pkg::BYTE_WIDTH-1:0] sum_ff, sum_in;
   logic                            hdr_ok_ff, hdr_ok_in;
   logic [fhls_pkg::BYTE_WIDTH-1:0] decl_ff, decl_in;

   logic                            pos_zero;
   logic                            pos_one;
   logic                            hdr_now;
   logic [fhls_pkg::BYTE_WIDTH-1:0] decl_now;
   logic [fhls_pkg::POS_WIDTH-1:0]  count;
   logic [fhls_pkg::POS_WIDTH-1:0]  decl_ext;
   fhls_pkg::verdict_type           verdict;

   assign pos_zero = (pos_ff == '0);
   assign pos_one  = (pos_ff == fhls_pkg::POS_WIDTH'(1));
   assign hdr_now  = pos_zero ? (data_byte == header_byte) : hdr_ok_ff;
   assign decl_now = pos_one ? data_byte : decl_ff;

   // count includes this word, saturating
   assign count    = (pos_ff == fhls_pkg::POS_MAX) ? fhls_pkg::POS_MAX
                                                   : pos_ff + fhls_pkg::POS_WIDTH'(1);
   // one-word frame sees a declared length of zero
   assign decl_ext = pos_zero ? '0 : {{(fhls_pkg::POS_WIDTH-fhls_pkg::BYTE_WIDTH){1'b0}},
                                      decl_now};

   always_comb begin
      if (!hdr_now) begin
         verdict = fhls_pkg::VERDICT_HEADER;
      end else if (decl_ext < count) begin
         verdict = fhls_pkg::VERDICT_SHORT;
      end else if (decl_ext > count) begin
         verdict = fhls_pkg::VERDICT_LONG;
      end else if (sum_ff != data_byte) begin
         verdict = fhls_pkg::VERDICT_SUM;
      end else begin
         verdict = fhls_pkg::VERDICT_OK;
      end
   end

   always_comb begin
      pos_in    = pos_ff;
      sum_in    = sum_ff;
      hdr_ok_in = hdr_ok_ff;
      decl_in   = decl_ff;
      if (go) begin
         if (frame_end) begin
            pos_in    = '0;
            sum_in    = '0;
            hdr_ok_in = 1'b0;
            decl_in   = '0;
         end else begin
            hdr_ok_in = hdr_now;
            decl_in   = decl_now;
            if (!pos_zero) begin
               sum_in = sum_ff + data_byte;
            end
            if (pos_ff != fhls_pkg::POS_MAX) begin
               pos_in = pos_ff + fhls_pkg::POS_WIDTH'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         sum_ff    <= '0;
         hdr_ok_ff <= 1'b0;
         decl_ff   <= '0;
      end else begin
         pos_ff    <= pos_in;
         sum_ff    <= sum_in;
         hdr_ok_ff <= hdr_ok_in;
         decl_ff   <= decl_in;
      end
   end

   assign result.valid   = go && frame_end;
   assign result.verdict = verdict;

endmodule
`default_nettype wire

/* src/frame_header_length_sum_check.sv */
// top level of the frame header, length and additive sum checker
//
//   channel   direction  handshake              payload
//   req       in         req_valid/req_stall    req_data_byte[7:0], req_frame_end
//   rsp       out        rsp_valid/rsp_stall    rsp_verdict[2:0]
//   csr       in/out     psel/penable/pready    paddr[2:0], pwdata/prdata[31:0]
//
// one word per cycle sustained except while rsp_stall holds a last word; a word passes
// the input register and its verdict (last word of a frame only) reaches the result register
// as the word leaves it; rsp_valid is driven by the result register
// synchronous active-high reset clears the frame state, handshake state and header byte
// rsp_stall only backs up the input register when a last word finds the result register full
`default_nettype none
module frame_header_length_sum_check (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // input words
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [fhls_pkg::BYTE_WIDTH-1:0]      req_data_byte,
   input  wire logic                                 req_frame_end,
   // verdicts
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic      [fhls_pkg::VERDICT_WIDTH-1:0]   rsp_verdict,
   // configuration
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [fhls_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  wire logic [fhls_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic      [fhls_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                      pready
);

   // input register
   logic                              in_valid_ff, in_valid_in;
   logic [fhls_pkg::BYTE_WIDTH-1:0]   in_byte_ff, in_byte_in;
   logic                              in_end_ff, in_end_in;

   // result register
   logic                              out_valid_ff, out_valid_in;
   fhls_pkg::verdict_type             out_verdict_ff, out_verdict_in;

   logic                              out_free;
   logic                              stage_go;
   logic                              req_take;
   logic [fhls_pkg::BYTE_WIDTH-1:0]   header_byte;
   fhls_pkg::check_result_type        result;

   fhls_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .header_byte (header_byte)
   );

   // result register can take a verdict when empty or being drained
   assign out_free  = !out_valid_ff || !rsp_stall;
   // a word without frame_end never needs the result register
   assign stage_go  = in_valid_ff && (!in_end_ff || out_free);
   assign req_stall = in_valid_ff && !stage_go;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_end_in   = in_end_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
      if (req_take) begin
         in_byte_in = req_data_byte;
         in_end_in  = req_frame_end;
      end
   end

   fhls_check u_check (
      .clock       (clock),
      .reset       (reset),
      .go          (stage_go),
      .data_byte   (in_byte_ff),
      .frame_end   (in_end_ff),
      .header_byte (header_byte),
      .result      (result)
   );

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_verdict_in = out_verdict_ff;
      if (result.valid) begin
         out_valid_in   = 1'b1;
         out_verdict_in = result.verdict;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_byte_ff     <= in_byte_in;
      in_end_ff      <= in_end_in;
      out_verdict_ff <= out_verdict_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_verdict = out_verdict_ff;

endmodule
`default_nettype wire

/* test/frame_header_length_sum_check_tb.sv */
// self-checking testbench for the frame header, length and additive sum checker

// predicts one verdict per frame from the words the block accepts
class frame_verdict_model;
   logic [7:0]                      header_byte = '0;
   logic [fhls_pkg::POS_WIDTH-1:0]  byte_count = '0;
   logic [7:0]                      running_sum = '0;
   bit                              header_ok = 1'b0;
   logic [7:0]                      declared_len = '0;
   fhls_pkg::verdict_type           pending_verdicts[$];
   int                              errors = 0;

   function void note_word(logic [7:0] data, bit last);
      logic [fhls_pkg::POS_WIDTH-1:0] pos;
      logic [9:0]                     received;
      logic [9:0]                     declared;
      fhls_pkg::verdict_type          verdict;
      pos = byte_count;
      if (pos == 0) begin
         header_ok = (data == header_byte);
      end else if (pos == 1) begin
         declared_len = data;
      end
      if (!last) begin
         if (pos != 0) begin
            running_sum = running_sum + data;
         end
         if (byte_count != fhls_pkg::POS_MAX) begin
            byte_count = byte_count + 1'b1;
         end
      end else begin
         received = (pos != fhls_pkg::POS_MAX) ? {1'b0, pos} + 10'd1 : {1'b0, pos};
         declared = (pos != 0) ? {2'b00, declared_len} : 10'd0;
         if (!header_ok) begin
            verdict = fhls_pkg::VERDICT_HEADER;
         end else if (declared < received) begin
            verdict = fhls_pkg::VERDICT_SHORT;
         end else if (declared > received) begin
            verdict = fhls_pkg::VERDICT_LONG;
         end else if (running_sum != data) begin
            verdict = fhls_pkg::VERDICT_SUM;
         end else begin
            verdict = fhls_pkg::VERDICT_OK;
         end
         pending_verdicts = {pending_verdicts, verdict};
         byte_count = '0;
         running_sum = '0;
         header_ok = 1'b0;
         declared_len = '0;
      end
   endfunction

   function void check_verdict(logic [fhls_pkg::VERDICT_WIDTH-1:0] got);
      fhls_pkg::verdict_type want;
      if (pending_verdicts.size() == 0) begin
         $display("%0t: unexpected verdict, expected none, actual %0d", $time, got);
         errors++;
      end else begin
         want = pending_verdicts.pop_front();
         if (got !== want) begin
            $display("%0t: verdict mismatch, expected %0d (%s), actual %0d",
                     $time, want, want.name(), got);
            errors++;
         end
      end
   endfunction
endclass

module frame_header_length_sum_check_tb;

   localparam int HALF_PERIOD = 2;
   localparam int RESET_CYCLES = 10;
   // a verdict shows after its last word has passed the input and result registers, keep a margin before the csr
   localparam int SETTLE_CYCLES = 4;
   // cycles with no word, verdict or csr access before giving up
   localparam int WATCHDOG_LIMIT = 2000;
   // small random frames per idling phase, counted in words
   localparam int PHASE_WORDS = 80;
   localparam logic [fhls_pkg::CSR_ADDR_WIDTH-1:0] ADDR_HEADER = 3'd0;
   // word address one past the only register, writes there must be dropped
   localparam logic [fhls_pkg::CSR_ADDR_WIDTH-1:0] ADDR_UNUSED = 3'd4;

   typedef enum {FLAW_NONE, FLAW_HEADER, FLAW_LENGTH, FLAW_SUM} frame_flaw_type;

   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_stall;
   logic [fhls_pkg::BYTE_WIDTH-1:0]       req_data_byte;
   logic                                  req_frame_end;
   logic                                  rsp_valid;
   logic                                  rsp_stall;
   logic [fhls_pkg::VERDICT_WIDTH-1:0]    rsp_verdict;
   logic                                  psel;
   logic                                  penable;
   logic                                  pwrite;
   logic [fhls_pkg::CSR_ADDR_WIDTH-1:0]   paddr;
   logic [fhls_pkg::CSR_DATA_WIDTH-1:0]   pwdata;
   logic [fhls_pkg::CSR_DATA_WIDTH-1:0]   prdata;
   logic                                  pready;

   frame_verdict_model verdicts = new;

   // idling in percent, changed per phase
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int words_sent = 0;
   int quiet_cycles = 0;

   frame_header_length_sum_check i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_frame_end (req_frame_end),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_verdict   (rsp_verdict),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   // receiver side: random stall decided at the falling edge
   always @(negedge clock) begin
      rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(99) < rsp_stall_pct);
   end

   // every verdict taken by the receiver goes to the predictor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         verdicts.check_verdict(rsp_verdict);
      end
   end

   // watchdog on cycles where nothing moves on any port
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable && pready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // one word on the input channel, entered and left at a falling edge
   task automatic push_word(input logic [7:0] data, input bit last);
      while ((send_idle_pct != 0) && ($urandom_range(99) < send_idle_pct)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_frame_end <= last;
      // payload stays put until the block takes it
      do @(posedge clock); while (req_stall !== 1'b0);
      verdicts.note_word(data, last);
      words_sent++;
      @(negedge clock);
   endtask

   // builds a frame against the current header and sends it word by word
   task automatic send_frame(input int len, input frame_flaw_type flaw);
      logic [7:0] frame_bytes[$];
      logic [7:0] sum;
      int         i;
      for (i = 0; i < len; i++) begin
         frame_bytes = {frame_bytes, 8'($urandom_range(255))};
      end
      frame_bytes[0] = verdicts.header_byte;
      if (flaw == FLAW_HEADER) begin
         frame_bytes[0] = frame_bytes[0] ^ 8'($urandom_range(1, 255));
      end
      // length byte is only right for frames up to 255 words
      if (len >= 2) begin
         frame_bytes[1] = 8'(len);
         if (flaw == FLAW_LENGTH) begin
            frame_bytes[1] = frame_bytes[1] ^ 8'($urandom_range(1, 255));
         end
      end
      // last word carries the sum of everything between header and itself
      if (len >= 3) begin
         sum = '0;
         for (i = 1; i < len - 1; i++) begin
            sum = sum + frame_bytes[i];
         end
         frame_bytes[len-1] = sum;
         if (flaw == FLAW_SUM) begin
            frame_bytes[len-1] = sum ^ 8'($urandom_range(1, 255));
         end
      end
      for (i = 0; i < len; i++) begin
         push_word(frame_bytes[i], i == len - 1);
      end
   endtask

   // one apb transfer: setup cycle, then access until pready
   task automatic csr_access(input bit write,
                             input logic [fhls_pkg::CSR_ADDR_WIDTH-1:0] addr,
                             input logic [fhls_pkg::CSR_DATA_WIDTH-1:0] data,
                             output logic [fhls_pkg::CSR_DATA_WIDTH-1:0] rdata);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= write;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      rdata = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // writes a register and reads the header back to confirm the stored value
   task automatic set_header(input logic [fhls_pkg::CSR_ADDR_WIDTH-1:0] addr,
                             input logic [7:0] value);
      logic [fhls_pkg::CSR_DATA_WIDTH-1:0] rdata;
      csr_access(1'b1, addr, {{(fhls_pkg::CSR_DATA_WIDTH-8){1'b0}}, value}, rdata);
      // only word index zero holds a register
      if (addr[fhls_pkg::CSR_ADDR_WIDTH-1:2] == fhls_pkg::CSR_IDX_HEADER) begin
         verdicts.header_byte = value;
      end
      csr_access(1'b0, ADDR_HEADER, '0, rdata);
      if (rdata !== {{(fhls_pkg::CSR_DATA_WIDTH-8){1'b0}}, verdicts.header_byte}) begin
         $display("%0t: header readback mismatch, expected %0h, actual %0h",
                  $time, verdicts.header_byte, rdata);
         verdicts.errors++;
      end
   endtask

   // waits for every verdict, then lets the pipeline empty out
   task automatic wait_idle();
      while (verdicts.pending_verdicts.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int             phase_start;
      int             len;
      int             pick;
      frame_flaw_type flaw;
      int             send_pct[4];
      int             stall_pct[4];
      logic [7:0]     phase_header[4];

      send_pct = '{0, 61, 0, 9};
      stall_pct = '{0, 0, 61, 9};
      phase_header = '{8'hFF, 8'h00, 8'($urandom_range(255)), 8'($urandom_range(255))};

      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = '0;
      req_frame_end = 1'b0;
      rsp_stall = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed frames against the header value left by reset
      // one-word frames: matching header reads as declared shorter
      push_word(8'h00, 1'b1);
      push_word(8'hFF, 1'b1);
      // two-word frames: declared zero, then declared right with an empty sum
      push_word(8'h00, 1'b0);
      push_word(8'h00, 1'b1);
      push_word(8'h00, 1'b0);
      push_word(8'h02, 1'b1);
      // clean three-word frame
      send_frame(3, FLAW_NONE);
      // declared longer than received
      push_word(8'h00, 1'b0);
      push_word(8'hFF, 1'b0);
      push_word(8'h00, 1'b0);
      push_word(8'hFF, 1'b1);
      send_frame(3, FLAW_HEADER);
      send_frame(4, FLAW_SUM);
      send_frame(5, FLAW_LENGTH);
      req_valid <= 1'b0;
      wait_idle();

      // random frames under each idling mix, new header each time
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = send_pct[phase];
         rsp_stall_pct = stall_pct[phase];
         set_header(ADDR_HEADER, phase_header[phase]);
         if (phase == 1) begin
            // write past the register file must leave the header alone
            set_header(ADDR_UNUSED, 8'($urandom_range(255)));
            // longest frame whose length byte can still be right
            send_frame(255, FLAW_NONE);
         end
         if (phase == 2) begin
            // word count runs into saturation
            send_frame(515, FLAW_NONE);
         end
         phase_start = words_sent;
         while (words_sent - phase_start < PHASE_WORDS) begin
            pick = $urandom_range(99);
            len = (pick < 10) ? $urandom_range(1, 2) : $urandom_range(3, 16);
            case ($urandom_range(9))
               0: flaw = FLAW_HEADER;
               1: flaw = FLAW_LENGTH;
               2: flaw = FLAW_SUM;
               default: flaw = FLAW_NONE;
            endcase
            send_frame(len, flaw);
         end
         req_valid <= 1'b0;
         wait_idle();
      end

      if (verdicts.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* files.f */
src/fhls_pkg.sv
src/fhls_csr.sv
src/fhls_check.sv
src/frame_header_length_sum_check.sv
test/frame_header_length_sum_check_tb.sv
